@@ sv/cssb_pkg.sv @@
// ----------------------------------------------------------------------------
// cssb_pkg
// Shared types for the cocktail shaker byte sorter: sequencer states and the
// status group that the sort sequencer returns to the top level.
// ----------------------------------------------------------------------------
package cssb_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F_PRIME,
        S_F_LOAD,
        S_F_STEP,
        S_F_END,
        S_B_PRIME,
        S_B_LOAD,
        S_B_STEP,
        S_B_END,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

endpackage

@@ sv/cssb_mem.sv @@
// ----------------------------------------------------------------------------
// cssb_mem
// Element store: one write port and one read port, registered read data
// that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module cssb_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/cssb_seq.sv @@
// ----------------------------------------------------------------------------
// cssb_seq
// Sort and drain sequencer. Runs forward and backward compare-swap passes
// over the store by read-modify-write, carrying the travelling element in a
// register, then reads the sorted bytes out one beat per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module cssb_seq #(
    parameter int AW           = 6,
    parameter int CW           = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CW-1:0]       i_count,
    input  logic [7:0]          i_rd_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [7:0]          o_wr_data,
    output logic                o_valid,
    output logic                o_last_result,
    input  logic                i_ready,
    output cssb_pkg::t_seq_stat o_stat
);

    cssb_pkg::t_state r_state;
    cssb_pkg::t_state n_state;

    logic [AW-1:0] r_lo;
    logic [AW-1:0] r_hi;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_mark;
    logic [7:0]    r_carry;
    logic [AW-1:0] r_optr;
    logic          r_ovalid;
    logic          r_olast;

    logic [AW-1:0] n_minus1;
    logic          f_swap;
    logic          b_swap;
    logic          out_adv;
    logic          out_end;
    logic [CW-1:0] cnt_m1;

    assign cnt_m1   = i_count - CW'(1);
    assign n_minus1 = cnt_m1[AW-1:0];
    assign f_swap   = r_carry > i_rd_data;
    assign b_swap   = i_rd_data > r_carry;
    assign out_adv  = !r_ovalid || i_ready;
    assign out_end  = r_ovalid && i_ready && r_olast;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cssb_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_count < CW'(2)) ? cssb_pkg::S_OUT : cssb_pkg::S_F_PRIME;
                end
            end
            cssb_pkg::S_F_PRIME: n_state = cssb_pkg::S_F_LOAD;
            cssb_pkg::S_F_LOAD:  n_state = cssb_pkg::S_F_STEP;
            cssb_pkg::S_F_STEP: begin
                if (r_i + AW'(1) == r_hi) begin
                    n_state = cssb_pkg::S_F_END;
                end
            end
            cssb_pkg::S_F_END: begin
                n_state = (r_lo < r_mark) ? cssb_pkg::S_B_PRIME : cssb_pkg::S_OUT;
            end
            cssb_pkg::S_B_PRIME: n_state = cssb_pkg::S_B_LOAD;
            cssb_pkg::S_B_LOAD:  n_state = cssb_pkg::S_B_STEP;
            cssb_pkg::S_B_STEP: begin
                if (r_i - AW'(1) == r_lo) begin
                    n_state = cssb_pkg::S_B_END;
                end
            end
            cssb_pkg::S_B_END: begin
                n_state = (r_mark < r_hi) ? cssb_pkg::S_F_PRIME : cssb_pkg::S_OUT;
            end
            cssb_pkg::S_OUT: begin
                if (out_end) begin
                    n_state = cssb_pkg::S_IDLE;
                end
            end
            default: n_state = cssb_pkg::S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        o_rd_en   = 1'b0;
        o_rd_addr = r_lo;
        o_wr_en   = 1'b0;
        o_wr_addr = r_i;
        o_wr_data = r_carry;
        case (r_state)
            cssb_pkg::S_F_PRIME: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_lo;
            end
            cssb_pkg::S_F_LOAD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_lo + AW'(1);
            end
            cssb_pkg::S_F_STEP: begin
                o_rd_en   = (r_i + AW'(1) != r_hi);
                o_rd_addr = r_i + AW'(2);
                o_wr_en   = 1'b1;
                o_wr_addr = r_i;
                o_wr_data = f_swap ? i_rd_data : r_carry;
            end
            cssb_pkg::S_F_END: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_hi;
            end
            cssb_pkg::S_B_PRIME: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_hi;
            end
            cssb_pkg::S_B_LOAD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_hi - AW'(1);
            end
            cssb_pkg::S_B_STEP: begin
                o_rd_en   = (r_i - AW'(1) != r_lo);
                o_rd_addr = r_i - AW'(2);
                o_wr_en   = 1'b1;
                o_wr_addr = r_i;
                o_wr_data = b_swap ? i_rd_data : r_carry;
            end
            cssb_pkg::S_B_END: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_lo;
            end
            cssb_pkg::S_OUT: begin
                o_rd_en   = out_adv && !out_end;
                o_rd_addr = r_optr;
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cssb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == cssb_pkg::S_OUT) begin
            if (out_end) begin
                r_ovalid <= 1'b0;
            end else if (out_adv) begin
                r_ovalid <= 1'b1;
            end
        end else begin
            r_ovalid <= 1'b0;
        end
    end

    // pass bounds, carry and drain pointer
    always_ff @(posedge i_clk) begin
        case (r_state)
            cssb_pkg::S_IDLE: begin
                r_lo   <= '0;
                r_hi   <= n_minus1;
                r_optr <= '0;
            end
            cssb_pkg::S_F_LOAD: begin
                r_carry <= i_rd_data;
                r_i     <= r_lo;
                r_mark  <= r_lo;
            end
            cssb_pkg::S_F_STEP: begin
                // carry the larger byte onwards
                if (f_swap) begin
                    r_mark <= r_i;
                end else begin
                    r_carry <= i_rd_data;
                end
                r_i <= r_i + AW'(1);
            end
            cssb_pkg::S_F_END: begin
                r_hi   <= r_mark;
                r_optr <= '0;
            end
            cssb_pkg::S_B_LOAD: begin
                r_carry <= i_rd_data;
                r_i     <= r_hi;
                r_mark  <= r_hi;
            end
            cssb_pkg::S_B_STEP: begin
                // carry the smaller byte downwards
                if (b_swap) begin
                    r_mark <= r_i;
                end else begin
                    r_carry <= i_rd_data;
                end
                r_i <= r_i - AW'(1);
            end
            cssb_pkg::S_B_END: begin
                r_lo   <= r_mark;
                r_optr <= '0;
            end
            cssb_pkg::S_OUT: begin
                if (out_adv && !out_end) begin
                    r_olast <= (r_optr == n_minus1);
                    r_optr  <= r_optr + AW'(1);
                end
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_last_result = r_olast;
    assign o_stat.busy   = (r_state != cssb_pkg::S_IDLE);
    assign o_stat.done   = out_end;

endmodule

@@ sv/cocktail_shaker_sort_bytes.sv @@
// ----------------------------------------------------------------------------
// cocktail_shaker_sort_bytes
// Collects a run of bytes into the element store, sorts it ascending with
// cocktail shaker passes and returns the sorted bytes, last one marked.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | i_valid / o_ready  | i_value, i_last_element
//  output  | out       | o_valid / i_ready  | o_sorted_value, o_last_result,
//          |           |                    | o_overflow
//
//  While loading, a byte is taken whenever i_valid is high. After the last byte
//  the sort runs alone, each pass working on the store's one read and one write
//  port. The sorted bytes then leave at one beat per cycle from the store's read
//  register; a stall on i_ready holds the beat. Input is not taken from the
//  last byte until the final beat of the run is accepted. Reset is synchronous.
//
module cocktail_shaker_sort_bytes #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_value,
    input  logic       i_last_element,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_sorted_value,
    output logic       o_last_result,
    output logic       o_overflow
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic          r_loading;
    logic          r_start;
    logic [CW-1:0] r_count;
    logic          r_ovf;

    logic          in_beat;
    logic          store_ok;
    logic          load_wr;

    logic          seq_rd_en;
    logic [AW-1:0] seq_rd_addr;
    logic          seq_wr_en;
    logic [AW-1:0] seq_wr_addr;
    logic [7:0]    seq_wr_data;
    logic [7:0]    rd_data;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;

    cssb_pkg::t_seq_stat seq_stat;

    assign o_ready  = r_loading;
    assign in_beat  = i_valid && r_loading;
    assign store_ok = r_count < CW'(MAX_ELEMENTS);
    assign load_wr  = in_beat && store_ok;

    // load bookkeeping: count, overflow, hand over to the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading <= 1'b1;
            r_start   <= 1'b0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_start <= in_beat && i_last_element;
            if (in_beat) begin
                if (store_ok) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_last_element) begin
                    r_loading <= 1'b0;
                end
            end else if (seq_stat.done) begin
                r_loading <= 1'b1;
                r_count   <= '0;
                r_ovf     <= 1'b0;
            end
        end
    end

    // store write port: loader while loading, sequencer otherwise
    always_comb begin
        if (r_loading) begin
            mem_wr_en   = load_wr;
            mem_wr_addr = r_count[AW-1:0];
            mem_wr_data = i_value;
        end else begin
            mem_wr_en   = seq_wr_en;
            mem_wr_addr = seq_wr_addr;
            mem_wr_data = seq_wr_data;
        end
    end

    cssb_mem #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (seq_rd_en),
        .i_rd_addr (seq_rd_addr),
        .o_rd_data (rd_data)
    );

    cssb_seq #(
        .AW           (AW),
        .CW           (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_start),
        .i_count       (r_count),
        .i_rd_data     (rd_data),
        .o_rd_en       (seq_rd_en),
        .o_rd_addr     (seq_rd_addr),
        .o_wr_en       (seq_wr_en),
        .o_wr_addr     (seq_wr_addr),
        .o_wr_data     (seq_wr_data),
        .o_valid       (o_valid),
        .o_last_result (o_last_result),
        .i_ready       (i_ready),
        .o_stat        (seq_stat)
    );

    assign o_sorted_value = rd_data;
    assign o_overflow     = r_ovf;

    // loading and draining never overlap
    a_load_drain_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result beat is valid");

    // sequencer stays idle while bytes are being loaded
    a_idle_when_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !seq_stat.busy)
        else $error("sequencer busy during loading");

    // dropped bytes only once the store is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CW'(MAX_ELEMENTS)))
        else $error("overflow flagged with room in the store");

    // final beat of a run returns the block to loading
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_result) |=> (o_ready && r_count == '0))
        else $error("block not reloading after final beat");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for cocktail_shaker_sort_bytes
// Feeds runs of bytes through the sorter and checks every sorted beat
// against a software copy of the shaker sort. The runs cover edge cases,
// a full store, dropped bytes and random runs with random idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PERCENT = 9;
    localparam int END_SETTLE = 200;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       ovf;
    } t_sorted_beat;

    typedef enum int {FILL_RANDOM, FILL_CLUSTERED, FILL_RISING, FILL_FALLING} t_fill;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_value;
    logic       i_last_element;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_sorted_value;
    logic       o_last_result;
    logic       o_overflow;

    // Sorter's view as the testbench keeps it
    logic [7:0]   run_store [0:STORE_DEPTH-1];
    int           run_count;
    logic         run_dropped;
    t_sorted_beat sorted_due [$];

    bit quiet;
    int errors;
    int cycle_count;
    int runs_seen;
    int overflow_runs;
    int bytes_in;
    int beats_checked;

    cocktail_shaker_sort_bytes #(
        .MAX_ELEMENTS(STORE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_last_result  (o_last_result),
        .o_overflow     (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sort the first n stored bytes with alternating passes, each pass
    // narrowing its bound to the last swap
    function automatic void shaker_sort_run(input int n);
        int lo;
        int hi;
        int mark;
        int k;
        logic [7:0] t;
        if (n < 2) return;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mark = lo;
            for (k = lo; k < hi; k++) begin
                if (run_store[k] > run_store[k+1]) begin
                    t = run_store[k];
                    run_store[k] = run_store[k+1];
                    run_store[k+1] = t;
                    mark = k;
                end
            end
            hi = mark;
            mark = hi;
            for (k = hi; k > lo; k--) begin
                if (run_store[k-1] > run_store[k]) begin
                    t = run_store[k-1];
                    run_store[k-1] = run_store[k];
                    run_store[k] = t;
                    mark = k;
                end
            end
            lo = mark;
        end
    endfunction

    // Store one accepted byte; on the closing byte queue the sorted run
    function automatic void take_byte(input logic [7:0] v, input logic last);
        int k;
        t_sorted_beat beat;
        if (run_count < STORE_DEPTH) begin
            run_store[run_count] = v;
            run_count++;
            bytes_in++;
        end else begin
            run_dropped = 1'b1;
        end
        if (last) begin
            shaker_sort_run(run_count);
            for (k = 0; k < run_count; k++) begin
                beat.value = run_store[k];
                beat.last  = (k == run_count - 1);
                beat.ovf   = run_dropped;
                sorted_due.push_back(beat);
            end
            runs_seen++;
            if (run_dropped) overflow_runs++;
            run_count = 0;
            run_dropped = 1'b0;
        end
    endfunction

    // Track accepted input beats and check every output beat
    always @(posedge i_clk) begin : beat_monitor
        t_sorted_beat due_beat;
        if (i_rst_n) begin
            if (i_valid && o_ready) take_byte(i_value, i_last_element);
            if (o_valid && i_ready) begin
                beats_checked++;
                if (sorted_due.size() == 0) begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: unexpected beat, value %02h last %b overflow %b",
                                 $time, o_sorted_value, o_last_result, o_overflow);
                end else begin
                    due_beat = sorted_due.pop_front();
                    if (o_sorted_value !== due_beat.value) begin
                        errors++;
                        if (errors < 50)
                            $display("%0t: sorted_value expected %02h, got %02h",
                                     $time, due_beat.value, o_sorted_value);
                    end
                    if (o_last_result !== due_beat.last) begin
                        errors++;
                        if (errors < 50)
                            $display("%0t: last_result expected %b, got %b",
                                     $time, due_beat.last, o_last_result);
                    end
                    if (o_overflow !== due_beat.ovf) begin
                        errors++;
                        if (errors < 50)
                            $display("%0t: overflow expected %b, got %b",
                                     $time, due_beat.ovf, o_overflow);
                    end
                end
            end
        end
    end

    // Stall the output side at random unless in a quiet stretch
    always @(posedge i_clk) begin
        i_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, sorted_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one byte after any idle cycles and hold it until accepted;
    // valid stays high on return
    task automatic send_byte(input logic [7:0] v, input logic last);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_value        <= v;
        i_last_element <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait for every queued beat to come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sorted_due.size() != 0) @(posedge i_clk);
    endtask

    // Single bytes, extremes, duplicates and falling order
    task automatic test_directed_edges();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hC8, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'h64, 1'b0);
        send_byte(8'h32, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h07, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h07, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h04, 1'b1);
    endtask

    // Fill the store exactly, closing on its last slot
    task automatic test_full_store();
        int k;
        for (k = 0; k < STORE_DEPTH; k++)
            send_byte(8'($urandom_range(255)), k == STORE_DEPTH - 1);
    endtask

    // Overrun the store; the closing byte is dropped but still ends the run,
    // and the next run must start with the flag clear
    task automatic test_overflow();
        int k;
        int extra;
        extra = $urandom_range(4, 1);
        for (k = 0; k < STORE_DEPTH + extra; k++)
            send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // Back-to-back runs of mostly small sizes with varied content
    task automatic test_random_runs(input int target);
        int sent;
        int size;
        int pick;
        int k;
        t_fill fill;
        logic [7:0] v;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70)      size = $urandom_range(8, 1);
            else if (pick < 92) size = $urandom_range(24, 9);
            else if (pick < 97) size = $urandom_range(STORE_DEPTH - 1, 25);
            else                size = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH);
            fill = t_fill'($urandom_range(3));
            for (k = 0; k < size; k++) begin
                case (fill)
                    FILL_RANDOM:    v = 8'($urandom_range(255));
                    FILL_CLUSTERED: v = 8'(120 + $urandom_range(3));
                    FILL_RISING:    v = 8'((k * 255) / size);
                    default:        v = 8'(255 - (k * 255) / size);
                endcase
                send_byte(v, k == size - 1);
            end
            sent += (size < STORE_DEPTH) ? size : STORE_DEPTH;
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_value        = 8'h00;
        i_last_element = 1'b0;
        i_ready        = 1'b0;
        quiet          = 1'b0;
        errors         = 0;
        cycle_count    = 0;
        run_count      = 0;
        run_dropped    = 1'b0;
        runs_seen      = 0;
        overflow_runs  = 0;
        bytes_in       = 0;
        beats_checked  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_full_store();
        test_overflow();
        test_random_runs(90);
        // Hold both sides busy for a stretch
        quiet = 1'b1;
        test_random_runs(50);
        quiet = 1'b0;

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Sorted %0d runs (%0d with dropped bytes) from %0d stored bytes,",
                 runs_seen, overflow_runs, bytes_in);
        $display("checking %0d output beats with random stalls on both sides.",
                 beats_checked);
        if (errors == 0 && sorted_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
